>>> hdl/tcspq_pkg.sv
// Package with the constants, codes and word types of the three-class priority queue.
package tcspq_pkg;

   // Ring geometry.
   localparam int QUEUE_DEPTH = 16;
   localparam int CLASS_COUNT = 3;
   localparam int ENTRY_COUNT = CLASS_COUNT * QUEUE_DEPTH;
   localparam int ADDR_WIDTH  = $clog2(ENTRY_COUNT);
   localparam int IDX_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   // Field widths.
   localparam int CLASS_WIDTH  = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int TAG_WIDTH    = 16;
   localparam int AGE_WIDTH    = 8;

   // Command kinds.
   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_SERVE   = 1'b1;

   // Priority classes.
   localparam logic [CLASS_WIDTH-1:0] CLASS_URGENT    = 2'd0;
   localparam logic [CLASS_WIDTH-1:0] CLASS_PREFERRED = 2'd1;
   localparam logic [CLASS_WIDTH-1:0] CLASS_NORMAL    = 2'd2;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SERVED   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DROPPED  = 2'd3;

   // Request word.
   typedef struct packed {
      logic                   kind;
      logic [CLASS_WIDTH-1:0] priority_class;
      logic [TAG_WIDTH-1:0]   record_tag;
      logic [AGE_WIDTH-1:0]   record_age;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [CLASS_WIDTH-1:0]  served_class;
      logic [TAG_WIDTH-1:0]    served_tag;
      logic [AGE_WIDTH-1:0]    served_age;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic [TAG_WIDTH-1:0] tag;
      logic [AGE_WIDTH-1:0] age;
   } record_type;

endpackage

>>> hdl/three_class_strict_priority_queue.sv
// Top level of the three-class strict priority queue with its shared record memory.
//
//  channel  | ports                  | direction | handshake
//  ---------+------------------------+-----------+---------------------------------
//  request  | start, busy, req_data  | in        | word taken when start & !busy
//  response | rsp_strobe, rsp_data   | out       | word valid for one cycle only
//
// Every request word gets exactly one response word, in the cycle after it is taken.
// A new word may be taken in every cycle; the record memory is read and written
// at one address each per cycle, and pointers and counts live in flip-flops.
// busy is high only during reset and in the first cycle after it.
// Reset clears all heads, tails and counts; the record memory is not cleared.
// The receiver cannot stall the response.
module three_class_strict_priority_queue
   import tcspq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // Ring pointers and fill counts, one per class.
   logic [IDX_WIDTH-1:0] head_ff [CLASS_COUNT];
   logic [IDX_WIDTH-1:0] head_in [CLASS_COUNT];
   logic [IDX_WIDTH-1:0] tail_ff [CLASS_COUNT];
   logic [IDX_WIDTH-1:0] tail_in [CLASS_COUNT];
   logic [CNT_WIDTH-1:0] fill_ff [CLASS_COUNT];
   logic [CNT_WIDTH-1:0] fill_in [CLASS_COUNT];

   // Response control registers.
   logic                    busy_ff;
   logic                    strobe_ff;
   logic                    strobe_in;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [STATUS_WIDTH-1:0] status_in;
   logic [CLASS_WIDTH-1:0]  class_ff;
   logic [CLASS_WIDTH-1:0]  class_in;

   // Record memory and its port signals.
   record_type              entry_mem [ENTRY_COUNT];
   record_type              rd_data_ff;
   logic                    mem_we;
   logic                    mem_re;
   logic [ADDR_WIDTH-1:0]   wr_addr;
   logic [ADDR_WIDTH-1:0]   rd_addr;

   // Decode helpers.
   logic                    accept;
   logic                    class_ok;
   logic [CLASS_WIDTH-1:0]  cls_idx;
   logic                    found;
   logic [CLASS_WIDTH-1:0]  serve_cls;
   logic                    enq_ok;

   assign accept = start && !busy_ff;

   // Advance a ring index with wrap at the end of the ring.
   function automatic logic [IDX_WIDTH-1:0] next_slot(input logic [IDX_WIDTH-1:0] slot);
      logic [IDX_WIDTH-1:0] nxt;
      if (slot == IDX_WIDTH'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + 1'b1;
      end
      return nxt;
   endfunction

   // Pick the class for an enqueue and the class to serve from.
   always_comb begin
      class_ok = (req_data.priority_class == CLASS_URGENT) ||
                 (req_data.priority_class == CLASS_PREFERRED) ||
                 (req_data.priority_class == CLASS_NORMAL);
      cls_idx  = class_ok ? req_data.priority_class : CLASS_URGENT;
      enq_ok   = class_ok && (fill_ff[cls_idx] != CNT_WIDTH'(QUEUE_DEPTH));
      priority if (fill_ff[CLASS_URGENT] != '0) begin
         found     = 1'b1;
         serve_cls = CLASS_URGENT;
      end else if (fill_ff[CLASS_PREFERRED] != '0) begin
         found     = 1'b1;
         serve_cls = CLASS_PREFERRED;
      end else if (fill_ff[CLASS_NORMAL] != '0) begin
         found     = 1'b1;
         serve_cls = CLASS_NORMAL;
      end else begin
         found     = 1'b0;
         serve_cls = CLASS_URGENT;
      end
   end

   // Next state of pointers and counts, memory port requests, response control.
   always_comb begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
         head_in[c] = head_ff[c];
         tail_in[c] = tail_ff[c];
         fill_in[c] = fill_ff[c];
      end
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      wr_addr   = ADDR_WIDTH'(cls_idx) * ADDR_WIDTH'(QUEUE_DEPTH)
                  + ADDR_WIDTH'(tail_ff[cls_idx]);
      rd_addr   = ADDR_WIDTH'(serve_cls) * ADDR_WIDTH'(QUEUE_DEPTH)
                  + ADDR_WIDTH'(head_ff[serve_cls]);
      strobe_in = accept;
      status_in = STATUS_EMPTY;
      class_in  = CLASS_URGENT;
      if (accept) begin
         unique case (req_data.kind)
            KIND_ENQUEUE: begin
               if (enq_ok) begin
                  mem_we           = 1'b1;
                  tail_in[cls_idx] = next_slot(tail_ff[cls_idx]);
                  fill_in[cls_idx] = fill_ff[cls_idx] + 1'b1;
                  status_in        = STATUS_ENQUEUED;
               end else begin
                  status_in = STATUS_DROPPED;
               end
            end
            KIND_SERVE: begin
               if (found) begin
                  mem_re             = 1'b1;
                  head_in[serve_cls] = next_slot(head_ff[serve_cls]);
                  fill_in[serve_cls] = fill_ff[serve_cls] - 1'b1;
                  status_in          = STATUS_SERVED;
                  class_in           = serve_cls;
               end
            end
            default: begin
               status_in = STATUS_EMPTY;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CLASS_COUNT; c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            fill_ff[c] <= '0;
         end
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         for (int c = 0; c < CLASS_COUNT; c++) begin
            head_ff[c] <= head_in[c];
            tail_ff[c] <= tail_in[c];
            fill_ff[c] <= fill_in[c];
         end
         busy_ff   <= 1'b0;
         strobe_ff <= strobe_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      class_ff  <= class_in;
   end

   // Record memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_addr] <= record_type'({req_data.record_tag, req_data.record_age});
      end
      if (mem_re) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // Outputs; record fields read as zero unless a record was served.
   assign busy                  = busy_ff;
   assign rsp_strobe            = strobe_ff;
   assign rsp_data.status       = status_ff;
   assign rsp_data.served_class = class_ff;
   assign rsp_data.served_tag   = (status_ff == STATUS_SERVED) ? rd_data_ff.tag : '0;
   assign rsp_data.served_age   = (status_ff == STATUS_SERVED) ? rd_data_ff.age : '0;

   // Every taken word gets a response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("response missing after a taken word");

   // No response appears without a taken word.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without a taken word");

   // Fill counts never exceed the ring depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff[0] <= CNT_WIDTH'(QUEUE_DEPTH)) && (fill_ff[1] <= CNT_WIDTH'(QUEUE_DEPTH)) &&
      (fill_ff[2] <= CNT_WIDTH'(QUEUE_DEPTH)))
      else $error("fill count beyond ring depth");

   // A serve with all rings empty reports nothing waiting.
   a_empty_serve: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.kind == KIND_SERVE) && (fill_ff[0] == '0) &&
       (fill_ff[1] == '0) && (fill_ff[2] == '0))
      |=> (rsp_data.status == STATUS_EMPTY))
      else $error("serve on empty rings did not report empty");

endmodule
